// ===== hdl/pshm_pkg.sv =====
package pshm_pkg;

    // field widths
    localparam int CntW     = 48;
    localparam int AgeW     = 16;
    localparam int TsW      = 64;
    localparam int HandleW  = 32;
    localparam int DevW     = 8;
    localparam int SeqW     = 16;
    localparam int PtsW     = 16;
    localparam int CmdW     = 2;
    localparam int StateW   = 2;
    localparam int CfgDataW = 32;
    localparam int CfgIdxW  = 3;

    // limits and reset values
    localparam logic [CntW-1:0] CNT_MAX             = '1;
    localparam logic [AgeW-1:0] AGE_MAX             = '1;
    localparam logic [AgeW-1:0] POINT_STALE_DEFAULT = 16'd2000;
    localparam logic [AgeW-1:0] IMU_STALE_DEFAULT   = 16'd1500;
    localparam logic [AgeW-1:0] GRACE_DEFAULT       = 16'd5000;

    typedef enum logic [CmdW-1:0] {
        CMD_POINT  = 2'd0,
        CMD_IMU    = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_REPORT = 2'd3
    } cmd_t;

    typedef enum logic [StateW-1:0] {
        STREAM_STARTING  = 2'd0,
        STREAM_STREAMING = 2'd1,
        STREAM_STALE     = 2'd2
    } stream_state_t;

    typedef enum logic [StateW-1:0] {
        IMU_IDLE   = 2'd0,
        IMU_ACTIVE = 2'd1,
        IMU_STALE  = 2'd2
    } imu_state_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MATCH_ENABLE  = 3'd0,
        REG_ACCEPT_HANDLE = 3'd1,
        REG_DEV_CODE      = 3'd2,
        REG_POINT_STALE   = 3'd3,
        REG_IMU_STALE     = 3'd4,
        REG_STARTUP_GRACE = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                match_enable;
        logic [HandleW-1:0]  accepted_handle;
        logic [DevW-1:0]     expected_dev_code;
        logic [AgeW-1:0]     point_stale_ticks;
        logic [AgeW-1:0]     imu_stale_ticks;
        logic [AgeW-1:0]     startup_grace_ticks;
    } cfg_t;

    typedef struct packed {
        cmd_t                command;
        logic [HandleW-1:0]  handle;
        logic [DevW-1:0]     dev_code;
        logic [SeqW-1:0]     sequence_req;
        logic [PtsW-1:0]     pkt_points;
        logic [TsW-1:0]      timestamp;
    } item_t;

    typedef struct packed {
        stream_state_t       stream_state;
        imu_state_t          imu_state;
        logic                loss_valid;
        logic [CntW-1:0]     point_packet_count;
        logic [CntW-1:0]     imu_packet_count;
        logic [CntW-1:0]     lost_packet_count;
        logic [CntW-1:0]     points_received;
        logic [CntW-1:0]     ivl_point_pkt_cnt;
        logic [CntW-1:0]     ivl_imu_pkt_cnt;
        logic [CntW-1:0]     ivl_point_sum;
        logic [TsW-1:0]      device_timestamp;
        logic [AgeW-1:0]     point_age_ticks;
    } result_t;

    // saturating counter add
    function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                                input logic [CntW-1:0] b);
        logic [CntW:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = sum[CntW] ? CNT_MAX : sum[CntW-1:0];
        end
    endfunction

    // saturating age increment
    function automatic logic [AgeW-1:0] age_inc(input logic [AgeW-1:0] a);
        begin
            age_inc = (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
        end
    endfunction

endpackage

// ===== hdl/pshm_if.sv =====
interface pshm_in_if;
    logic                         valid;
    logic                         ready;
    logic [pshm_pkg::CmdW-1:0]    command;
    logic [pshm_pkg::HandleW-1:0] handle;
    logic [pshm_pkg::DevW-1:0]    dev_code;
    logic [pshm_pkg::SeqW-1:0]    sequence_req;
    logic [pshm_pkg::PtsW-1:0]    pkt_points;
    logic [pshm_pkg::TsW-1:0]     timestamp;

    modport source (
        output valid, command, handle, dev_code, sequence_req, pkt_points, timestamp,
        input  ready
    );
    modport sink (
        input  valid, command, handle, dev_code, sequence_req, pkt_points, timestamp,
        output ready
    );
endinterface

interface pshm_out_if;
    logic                        valid;
    logic                        ready;
    logic [pshm_pkg::StateW-1:0] stream_state;
    logic [pshm_pkg::StateW-1:0] imu_state;
    logic                        loss_valid;
    logic [pshm_pkg::CntW-1:0]   point_packet_count;
    logic [pshm_pkg::CntW-1:0]   imu_packet_count;
    logic [pshm_pkg::CntW-1:0]   lost_packet_count;
    logic [pshm_pkg::CntW-1:0]   points_received;
    logic [pshm_pkg::CntW-1:0]   ivl_point_pkt_cnt;
    logic [pshm_pkg::CntW-1:0]   ivl_imu_pkt_cnt;
    logic [pshm_pkg::CntW-1:0]   ivl_point_sum;
    logic [pshm_pkg::TsW-1:0]    device_timestamp;
    logic [pshm_pkg::AgeW-1:0]   point_age_ticks;

    modport source (
        output valid, stream_state, imu_state, loss_valid, point_packet_count,
               imu_packet_count, lost_packet_count, points_received,
               ivl_point_pkt_cnt, ivl_imu_pkt_cnt, ivl_point_sum,
               device_timestamp, point_age_ticks,
        input  ready
    );
    modport sink (
        input  valid, stream_state, imu_state, loss_valid, point_packet_count,
               imu_packet_count, lost_packet_count, points_received,
               ivl_point_pkt_cnt, ivl_imu_pkt_cnt, ivl_point_sum,
               device_timestamp, point_age_ticks,
        output ready
    );
endinterface

// ===== hdl/packet_stream_health_monitor_unit.sv =====
// channel  | dir | handshake      | payload
// ---------+-----+----------------+------------------------------------------------
// in_ch    | in  | valid / ready  | command, handle, dev_code, sequence_req,
//          |     |                | pkt_points, timestamp
// out_ch   | out | valid / ready  | report: states, loss_valid, counters,
//          |     |                | device_timestamp, point_age_ticks
// cfg      | in  | cfg_wr_en      | cfg_index, cfg_wdata (no read-back)
//
// one transaction per cycle sustained while no report waits for out_ch: input register, update logic, result register
// a report passes from the input register into the result register and is presented on out_ch from there
// reset clears all counters, timers and flags; configuration returns to its defaults
// a report held in the input stage waits only while the result register is full and
// out_ch.ready is low; in_ch.ready drops only behind such a waiting report
module packet_stream_health_monitor_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    pshm_in_if.sink                        in_ch,
    pshm_out_if.source                     out_ch,
    input  logic                           cfg_wr_en,
    input  logic [pshm_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [pshm_pkg::CfgDataW-1:0]  cfg_wdata
);

    pshm_pkg::cfg_t  cfg;
    pshm_pkg::item_t item;
    logic            item_valid;
    logic            item_take;

    // configuration registers
    pshm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register
    pshm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .item_take  (item_take),
        .item_valid (item_valid),
        .item       (item)
    );

    // counters, timers and result register
    pshm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_ch     (out_ch)
    );

endmodule

// ===== hdl/pshm_cfg_regs.sv =====
module pshm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [pshm_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [pshm_pkg::CfgDataW-1:0]  cfg_wdata,
    output pshm_pkg::cfg_t                 cfg
);

    pshm_pkg::cfg_t cfg_reg;
    pshm_pkg::cfg_t cfg_next;

    // register decode, writes beyond the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (pshm_pkg::cfg_reg_t'(cfg_index))
                pshm_pkg::REG_MATCH_ENABLE:  cfg_next.match_enable = cfg_wdata[0];
                pshm_pkg::REG_ACCEPT_HANDLE:
                    cfg_next.accepted_handle = cfg_wdata[pshm_pkg::HandleW-1:0];
                pshm_pkg::REG_DEV_CODE:
                    cfg_next.expected_dev_code = cfg_wdata[pshm_pkg::DevW-1:0];
                pshm_pkg::REG_POINT_STALE:
                    cfg_next.point_stale_ticks = cfg_wdata[pshm_pkg::AgeW-1:0];
                pshm_pkg::REG_IMU_STALE:
                    cfg_next.imu_stale_ticks = cfg_wdata[pshm_pkg::AgeW-1:0];
                pshm_pkg::REG_STARTUP_GRACE:
                    cfg_next.startup_grace_ticks = cfg_wdata[pshm_pkg::AgeW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_enable        <= 1'b0;
            cfg_reg.accepted_handle     <= '0;
            cfg_reg.expected_dev_code   <= '0;
            cfg_reg.point_stale_ticks   <= pshm_pkg::POINT_STALE_DEFAULT;
            cfg_reg.imu_stale_ticks     <= pshm_pkg::IMU_STALE_DEFAULT;
            cfg_reg.startup_grace_ticks <= pshm_pkg::GRACE_DEFAULT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/pshm_in_stage.sv =====
module pshm_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    pshm_in_if.sink           in_ch,
    input  logic              item_take,
    output logic              item_valid,
    output pshm_pkg::item_t   item
);

    logic            item_valid_reg;
    logic            item_valid_next;
    pshm_pkg::item_t item_reg;
    pshm_pkg::item_t item_next;
    logic            in_fire;

    // stage frees up whenever the core consumes the held transaction
    assign in_ch.ready = !item_valid_reg || item_take;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        item_next       = item_reg;
        item_valid_next = item_valid_reg;
        if (in_fire)
        begin
            item_next.command      = pshm_pkg::cmd_t'(in_ch.command);
            item_next.handle       = in_ch.handle;
            item_next.dev_code     = in_ch.dev_code;
            item_next.sequence_req = in_ch.sequence_req;
            item_next.pkt_points   = in_ch.pkt_points;
            item_next.timestamp    = in_ch.timestamp;
            item_valid_next        = 1'b1;
        end
        else if (item_take)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

// ===== hdl/pshm_core.sv =====
module pshm_core (
    input  logic              clk,
    input  logic              rst_n,
    input  pshm_pkg::cfg_t    cfg,
    input  logic              item_valid,
    input  pshm_pkg::item_t   item,
    output logic              item_take,
    pshm_out_if.source        out_ch
);

    localparam int CntW = pshm_pkg::CntW;
    localparam int AgeW = pshm_pkg::AgeW;
    localparam int SeqW = pshm_pkg::SeqW;
    localparam int PtsW = pshm_pkg::PtsW;

    logic [CntW-1:0]          point_packets_reg, point_packets_next;
    logic [CntW-1:0]          imu_packets_reg, imu_packets_next;
    logic [CntW-1:0]          points_total_reg, points_total_next;
    logic [CntW-1:0]          lost_packets_reg, lost_packets_next;
    logic [CntW-1:0]          ival_point_pkts_reg, ival_point_pkts_next;
    logic [CntW-1:0]          ival_imu_pkts_reg, ival_imu_pkts_next;
    logic [CntW-1:0]          ival_pts_reg, ival_pts_next;
    logic                     have_sequence_reg, have_sequence_next;
    logic [SeqW-1:0]          last_sequence_reg, last_sequence_next;
    logic                     have_point_time_reg, have_point_time_next;
    logic                     have_imu_time_reg, have_imu_time_next;
    logic [AgeW-1:0]          point_age_reg, point_age_next;
    logic [AgeW-1:0]          imu_age_reg, imu_age_next;
    logic [AgeW-1:0]          uptime_reg, uptime_next;
    logic [pshm_pkg::TsW-1:0] last_ts_reg, last_ts_next;

    logic                     out_valid_reg, out_valid_next;
    pshm_pkg::result_t        result_reg, result_next;
    pshm_pkg::result_t        report;

    logic                     is_report;
    logic                     pkt_match;
    logic [SeqW-1:0]          seq_gap;
    logic                     gap_lost;
    logic [CntW-1:0]          pts_ext;
    logic [CntW-1:0]          lost_ext;

    // a report waits only for room in the result register
    assign is_report = (item.command == pshm_pkg::CMD_REPORT);
    assign item_take = item_valid && (!is_report || !out_valid_reg || out_ch.ready);

    // packet filter and sequence gap
    assign pkt_match = cfg.match_enable && (item.handle == cfg.accepted_handle)
                       && (item.dev_code == cfg.expected_dev_code);
    assign seq_gap   = item.sequence_req - last_sequence_reg;
    assign gap_lost  = have_sequence_reg && !seq_gap[SeqW-1] && (seq_gap > SeqW'(1));
    assign pts_ext   = {{(CntW-PtsW){1'b0}}, item.pkt_points};
    assign lost_ext  = {{(CntW-SeqW){1'b0}}, seq_gap - SeqW'(1)};

    // report snapshot from current state
    always_comb
    begin
        report = '0;
        if (have_point_time_reg && (point_age_reg <= cfg.point_stale_ticks))
            report.stream_state = pshm_pkg::STREAM_STREAMING;
        else if (uptime_reg >= cfg.startup_grace_ticks)
            report.stream_state = pshm_pkg::STREAM_STALE;
        else
            report.stream_state = pshm_pkg::STREAM_STARTING;
        if (!have_imu_time_reg)
            report.imu_state = pshm_pkg::IMU_IDLE;
        else if (imu_age_reg <= cfg.imu_stale_ticks)
            report.imu_state = pshm_pkg::IMU_ACTIVE;
        else
            report.imu_state = pshm_pkg::IMU_STALE;
        report.loss_valid         = have_sequence_reg && (point_packets_reg > CntW'(1));
        report.point_packet_count = point_packets_reg;
        report.imu_packet_count   = imu_packets_reg;
        report.lost_packet_count  = lost_packets_reg;
        report.points_received    = points_total_reg;
        report.ivl_point_pkt_cnt  = ival_point_pkts_reg;
        report.ivl_imu_pkt_cnt    = ival_imu_pkts_reg;
        report.ivl_point_sum      = ival_pts_reg;
        report.device_timestamp   = have_point_time_reg ? last_ts_reg : '0;
        report.point_age_ticks    = have_point_time_reg ? point_age_reg : '0;
    end

    // state update per transaction
    always_comb
    begin
        point_packets_next   = point_packets_reg;
        imu_packets_next     = imu_packets_reg;
        points_total_next    = points_total_reg;
        lost_packets_next    = lost_packets_reg;
        ival_point_pkts_next = ival_point_pkts_reg;
        ival_imu_pkts_next   = ival_imu_pkts_reg;
        ival_pts_next        = ival_pts_reg;
        have_sequence_next   = have_sequence_reg;
        last_sequence_next   = last_sequence_reg;
        have_point_time_next = have_point_time_reg;
        have_imu_time_next   = have_imu_time_reg;
        point_age_next       = point_age_reg;
        imu_age_next         = imu_age_reg;
        uptime_next          = uptime_reg;
        last_ts_next         = last_ts_reg;
        if (item_take)
        begin
            case (item.command)
                pshm_pkg::CMD_POINT:
                begin
                    if (pkt_match)
                    begin
                        point_packets_next   = pshm_pkg::sat_add(point_packets_reg, CntW'(1));
                        ival_point_pkts_next = pshm_pkg::sat_add(ival_point_pkts_reg,
                                                                 CntW'(1));
                        points_total_next    = pshm_pkg::sat_add(points_total_reg, pts_ext);
                        ival_pts_next        = pshm_pkg::sat_add(ival_pts_reg, pts_ext);
                        if (gap_lost)
                            lost_packets_next = pshm_pkg::sat_add(lost_packets_reg, lost_ext);
                        have_sequence_next   = 1'b1;
                        last_sequence_next   = item.sequence_req;
                        have_point_time_next = 1'b1;
                        point_age_next       = '0;
                        last_ts_next         = item.timestamp;
                    end
                end
                pshm_pkg::CMD_IMU:
                begin
                    if (pkt_match)
                    begin
                        imu_packets_next   = pshm_pkg::sat_add(imu_packets_reg, CntW'(1));
                        ival_imu_pkts_next = pshm_pkg::sat_add(ival_imu_pkts_reg, CntW'(1));
                        have_imu_time_next = 1'b1;
                        imu_age_next       = '0;
                    end
                end
                pshm_pkg::CMD_TICK:
                begin
                    point_age_next = pshm_pkg::age_inc(point_age_reg);
                    imu_age_next   = pshm_pkg::age_inc(imu_age_reg);
                    uptime_next    = pshm_pkg::age_inc(uptime_reg);
                end
                pshm_pkg::CMD_REPORT:
                begin
                    ival_point_pkts_next = '0;
                    ival_imu_pkts_next   = '0;
                    ival_pts_next        = '0;
                end
                default: ;
            endcase
        end
    end

    // result register control
    always_comb
    begin
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        if (item_take && is_report)
        begin
            result_next    = report;
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_packets_reg   <= '0;
            imu_packets_reg     <= '0;
            points_total_reg    <= '0;
            lost_packets_reg    <= '0;
            ival_point_pkts_reg <= '0;
            ival_imu_pkts_reg   <= '0;
            ival_pts_reg        <= '0;
            have_sequence_reg   <= 1'b0;
            last_sequence_reg   <= '0;
            have_point_time_reg <= 1'b0;
            have_imu_time_reg   <= 1'b0;
            point_age_reg       <= '0;
            imu_age_reg         <= '0;
            uptime_reg          <= '0;
            last_ts_reg         <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            point_packets_reg   <= point_packets_next;
            imu_packets_reg     <= imu_packets_next;
            points_total_reg    <= points_total_next;
            lost_packets_reg    <= lost_packets_next;
            ival_point_pkts_reg <= ival_point_pkts_next;
            ival_imu_pkts_reg   <= ival_imu_pkts_next;
            ival_pts_reg        <= ival_pts_next;
            have_sequence_reg   <= have_sequence_next;
            last_sequence_reg   <= last_sequence_next;
            have_point_time_reg <= have_point_time_next;
            have_imu_time_reg   <= have_imu_time_next;
            point_age_reg       <= point_age_next;
            imu_age_reg         <= imu_age_next;
            uptime_reg          <= uptime_next;
            last_ts_reg         <= last_ts_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // drive output channel
    assign out_ch.valid              = out_valid_reg;
    assign out_ch.stream_state       = result_reg.stream_state;
    assign out_ch.imu_state          = result_reg.imu_state;
    assign out_ch.loss_valid         = result_reg.loss_valid;
    assign out_ch.point_packet_count = result_reg.point_packet_count;
    assign out_ch.imu_packet_count   = result_reg.imu_packet_count;
    assign out_ch.lost_packet_count  = result_reg.lost_packet_count;
    assign out_ch.points_received    = result_reg.points_received;
    assign out_ch.ivl_point_pkt_cnt  = result_reg.ivl_point_pkt_cnt;
    assign out_ch.ivl_imu_pkt_cnt    = result_reg.ivl_imu_pkt_cnt;
    assign out_ch.ivl_point_sum      = result_reg.ivl_point_sum;
    assign out_ch.device_timestamp   = result_reg.device_timestamp;
    assign out_ch.point_age_ticks    = result_reg.point_age_ticks;

endmodule

// ===== verif/packet_stream_health_monitor_unit_test.sv =====
`timescale 1ns / 1ps

module packet_stream_health_monitor_unit_test;
    import pshm_pkg::*;

    localparam int  CLK_HALF_NS    = 2;
    localparam int  RESET_CYCLES   = 10;
    localparam int  IDLE_PCT       = 34;
    localparam int  SETTLE_CYCLES  = 6;
    localparam int  PHASE_COUNT    = 10;
    localparam int  PHASE_ITEMS    = 105;
    localparam int  TIMEOUT_NS     = 4_000_000;

    // register indexes past the end of the register map
    localparam logic [CfgIdxW-1:0] SPARE_IDX_LO = 3'd6;
    localparam logic [CfgIdxW-1:0] SPARE_IDX_HI = 3'd7;

    logic clk;
    logic rst_n;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_wdata;

    pshm_in_if  in_ch ();
    pshm_out_if out_ch ();

    packet_stream_health_monitor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shared idling level for both channels
    int idle_pct = IDLE_PCT;

    int mismatch_count = 0;
    int items_sent     = 0;
    int reports_seen   = 0;
    int reg_writes     = 0;

    // shadow of the configuration registers
    cfg_t cfg_shadow;

    // shadow of the monitor state
    logic [CntW-1:0] point_pkts_m     = '0;
    logic [CntW-1:0] imu_pkts_m       = '0;
    logic [CntW-1:0] points_total_m   = '0;
    logic [CntW-1:0] lost_pkts_m      = '0;
    logic [CntW-1:0] ivl_point_pkts_m = '0;
    logic [CntW-1:0] ivl_imu_pkts_m   = '0;
    logic [CntW-1:0] ivl_points_m     = '0;
    bit              seq_seen_m       = 1'b0;
    bit              point_seen_m     = 1'b0;
    bit              imu_seen_m       = 1'b0;
    logic [SeqW-1:0] last_seq_m       = '0;
    logic [AgeW-1:0] point_age_m      = '0;
    logic [AgeW-1:0] imu_age_m        = '0;
    logic [AgeW-1:0] uptime_m         = '0;
    logic [TsW-1:0]  last_ts_m        = '0;

    // reports predicted but not yet seen on out_ch
    result_t pending_reports[$];

    // clock
    initial clk = 1'b0;
    always #(CLK_HALF_NS) clk = ~clk;

    // saturating 48-bit counter add
    function automatic logic [CntW-1:0] count_add(input logic [CntW-1:0] a,
                                                  input logic [CntW-1:0] b);
        return (b > (CNT_MAX - a)) ? CNT_MAX : a + b;
    endfunction

    // saturating tick age
    function automatic logic [AgeW-1:0] age_step(input logic [AgeW-1:0] a);
        return (&a) ? a : a + 16'd1;
    endfunction

    function automatic bit packet_matches(input item_t it);
        return cfg_shadow.match_enable && it.handle == cfg_shadow.accepted_handle &&
               it.dev_code == cfg_shadow.expected_dev_code;
    endfunction

    // apply one register write to the shadow configuration
    task automatic apply_reg_write(input logic [CfgIdxW-1:0] idx,
                                   input logic [CfgDataW-1:0] data);
        case (idx)
            REG_MATCH_ENABLE:  cfg_shadow.match_enable        = data[0];
            REG_ACCEPT_HANDLE: cfg_shadow.accepted_handle     = data[HandleW-1:0];
            REG_DEV_CODE:      cfg_shadow.expected_dev_code   = data[DevW-1:0];
            REG_POINT_STALE:   cfg_shadow.point_stale_ticks   = data[AgeW-1:0];
            REG_IMU_STALE:     cfg_shadow.imu_stale_ticks     = data[AgeW-1:0];
            REG_STARTUP_GRACE: cfg_shadow.startup_grace_ticks = data[AgeW-1:0];
            default: ;
        endcase
    endtask

    // advance the monitor state by one transaction, queue a report if one is due
    task automatic update_monitor_model(input item_t it);
        result_t         rep;
        logic [SeqW-1:0] step;
        bit              take;
        take = packet_matches(it);
        case (it.command)
            CMD_POINT:
            begin
                if (take)
                begin
                    point_pkts_m     = count_add(point_pkts_m, 48'd1);
                    ivl_point_pkts_m = count_add(ivl_point_pkts_m, 48'd1);
                    points_total_m   = count_add(points_total_m, 48'(it.pkt_points));
                    ivl_points_m     = count_add(ivl_points_m, 48'(it.pkt_points));
                    if (seq_seen_m)
                    begin
                        step = it.sequence_req - last_seq_m;
                        // forward gaps only; repeats and reorders lose nothing
                        if (step > 16'd1 && step < 16'h8000)
                            lost_pkts_m = count_add(lost_pkts_m, 48'(step) - 48'd1);
                    end
                    seq_seen_m   = 1'b1;
                    last_seq_m   = it.sequence_req;
                    point_seen_m = 1'b1;
                    point_age_m  = '0;
                    last_ts_m    = it.timestamp;
                end
            end
            CMD_IMU:
            begin
                if (take)
                begin
                    imu_pkts_m     = count_add(imu_pkts_m, 48'd1);
                    ivl_imu_pkts_m = count_add(ivl_imu_pkts_m, 48'd1);
                    imu_seen_m     = 1'b1;
                    imu_age_m      = '0;
                end
            end
            CMD_TICK:
            begin
                point_age_m = age_step(point_age_m);
                imu_age_m   = age_step(imu_age_m);
                uptime_m    = age_step(uptime_m);
            end
            default:
            begin
                if (point_seen_m && point_age_m <= cfg_shadow.point_stale_ticks)
                    rep.stream_state = STREAM_STREAMING;
                else if (uptime_m >= cfg_shadow.startup_grace_ticks)
                    rep.stream_state = STREAM_STALE;
                else
                    rep.stream_state = STREAM_STARTING;
                if (!imu_seen_m)
                    rep.imu_state = IMU_IDLE;
                else if (imu_age_m <= cfg_shadow.imu_stale_ticks)
                    rep.imu_state = IMU_ACTIVE;
                else
                    rep.imu_state = IMU_STALE;
                rep.loss_valid         = seq_seen_m && point_pkts_m > 48'd1;
                rep.point_packet_count = point_pkts_m;
                rep.imu_packet_count   = imu_pkts_m;
                rep.lost_packet_count  = lost_pkts_m;
                rep.points_received    = points_total_m;
                rep.ivl_point_pkt_cnt  = ivl_point_pkts_m;
                rep.ivl_imu_pkt_cnt    = ivl_imu_pkts_m;
                rep.ivl_point_sum      = ivl_points_m;
                rep.device_timestamp   = point_seen_m ? last_ts_m : '0;
                rep.point_age_ticks    = point_seen_m ? point_age_m : '0;
                pending_reports.push_back(rep);
                ivl_point_pkts_m = '0;
                ivl_imu_pkts_m   = '0;
                ivl_points_m     = '0;
            end
        endcase
    endtask

    // drive one transaction on in_ch and wait for it to be taken
    task automatic send_item(input item_t it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.command      = it.command;
        in_ch.handle       = it.handle;
        in_ch.dev_code     = it.dev_code;
        in_ch.sequence_req = it.sequence_req;
        in_ch.pkt_points   = it.pkt_points;
        in_ch.timestamp    = it.timestamp;
        in_ch.valid        = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        update_monitor_model(it);
    endtask

    // stop sending, wait for all reports, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge clk);
        apply_reg_write(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // 16-bit register value with junk in the unused upper bits
    function automatic logic [CfgDataW-1:0] with_junk16(input logic [AgeW-1:0] v);
        return {16'($urandom_range(65535)), v};
    endfunction

    // item with random content in every field
    function automatic item_t random_fields(input cmd_t cmd);
        item_t it;
        it.command      = cmd;
        it.handle       = $urandom;
        it.dev_code     = 8'($urandom_range(255));
        it.sequence_req = 16'($urandom_range(65535));
        it.pkt_points   = 16'($urandom_range(65535));
        it.timestamp    = {$urandom, $urandom};
        return it;
    endfunction

    // point or IMU packet addressed to the configured device
    function automatic item_t matched_packet(input cmd_t cmd, input logic [SeqW-1:0] seq,
                                             input logic [PtsW-1:0] pts,
                                             input logic [TsW-1:0] ts);
        item_t it;
        it              = random_fields(cmd);
        it.handle       = cfg_shadow.accepted_handle;
        it.dev_code     = cfg_shadow.expected_dev_code;
        it.sequence_req = seq;
        it.pkt_points   = pts;
        it.timestamp    = ts;
        return it;
    endfunction

    // next sequence number: mostly in order, with gaps, repeats and reorders
    function automatic logic [SeqW-1:0] next_sequence(input logic [SeqW-1:0] prev);
        int r;
        r = $urandom_range(99);
        if (r < 70)      return prev + 16'd1;
        else if (r < 80) return prev + 16'($urandom_range(2, 40));
        else if (r < 85) return prev + 16'($urandom_range(2, 32767));
        else if (r < 90) return prev;
        else if (r < 95) return prev - 16'($urandom_range(1, 20));
        else             return 16'($urandom_range(65535));
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // report checker
    always @(posedge clk)
    begin
        result_t rep;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: report transaction with no report expected", $time);
                mismatch_count++;
            end
            else
            begin
                rep = pending_reports.pop_front();
                reports_seen++;
                check_field("stream_state", rep.stream_state, out_ch.stream_state);
                check_field("imu_state", rep.imu_state, out_ch.imu_state);
                check_field("loss_valid", rep.loss_valid, out_ch.loss_valid);
                check_field("point_packet_count", rep.point_packet_count,
                            out_ch.point_packet_count);
                check_field("imu_packet_count", rep.imu_packet_count, out_ch.imu_packet_count);
                check_field("lost_packet_count", rep.lost_packet_count,
                            out_ch.lost_packet_count);
                check_field("points_received", rep.points_received, out_ch.points_received);
                check_field("ivl_point_pkt_cnt", rep.ivl_point_pkt_cnt,
                            out_ch.ivl_point_pkt_cnt);
                check_field("ivl_imu_pkt_cnt", rep.ivl_imu_pkt_cnt, out_ch.ivl_imu_pkt_cnt);
                check_field("ivl_point_sum", rep.ivl_point_sum, out_ch.ivl_point_sum);
                check_field("device_timestamp", rep.device_timestamp, out_ch.device_timestamp);
                check_field("point_age_ticks", rep.point_age_ticks, out_ch.point_age_ticks);
            end
        end
    end

    // random backpressure on out_ch
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= idle_pct);
        end
    end

    // report right after reset, and a packet while matching is off
    task automatic test_idle_after_reset();
        send_item(random_fields(CMD_REPORT));
        send_item(matched_packet(CMD_POINT, 16'd5, 16'd100, 64'd7));
        send_item(random_fields(CMD_REPORT));
        settle();
    endtask

    // no point packet yet: starting until uptime reaches the grace, then stale
    task automatic test_startup_grace();
        repeat (3) send_item(random_fields(CMD_TICK));
        send_item(random_fields(CMD_REPORT));
        settle();
        write_reg(REG_STARTUP_GRACE, with_junk16(16'd3));
        send_item(random_fields(CMD_REPORT));
        settle();
        write_reg(REG_STARTUP_GRACE, with_junk16(16'd4));
        send_item(random_fields(CMD_REPORT));
        settle();
        write_reg(REG_STARTUP_GRACE, with_junk16(16'd0));
        send_item(random_fields(CMD_REPORT));
        settle();
        write_reg(REG_STARTUP_GRACE, with_junk16(GRACE_DEFAULT));
    endtask

    // sequence wrap, largest gap, repeat, reorder, rejected packets, field extremes
    task automatic test_sequence_gaps();
        item_t it;
        write_reg(SPARE_IDX_LO, '1);
        write_reg(SPARE_IDX_HI, $urandom);
        write_reg(REG_MATCH_ENABLE, 32'hFFFF_FFFF);
        write_reg(REG_ACCEPT_HANDLE, 32'hFFFF_FFFF);
        write_reg(REG_DEV_CODE, 32'h5A5A_A5FF);
        send_item(matched_packet(CMD_POINT, 16'hFFFF, 16'hFFFF, '1));
        send_item(matched_packet(CMD_POINT, 16'h0000, 16'd1, '0));
        send_item(matched_packet(CMD_POINT, 16'h7FFF, 16'd0, 64'h0123_4567_89AB_CDEF));
        send_item(matched_packet(CMD_POINT, 16'h7FFF, 16'd3, 64'hFEDC_BA98_7654_3210));
        send_item(matched_packet(CMD_POINT, 16'h8001, 16'd9, 64'h8000_0000_0000_0001));
        send_item(matched_packet(CMD_POINT, 16'h0001, 16'd2, 64'h7FFF_FFFF_FFFF_FFFE));
        send_item(matched_packet(CMD_IMU, '0, '0, '0));
        it        = matched_packet(CMD_POINT, 16'h0005, 16'd50, '1);
        it.handle = 32'hFFFF_FFFE;
        send_item(it);
        it          = matched_packet(CMD_IMU, '0, '0, '0);
        it.dev_code = 8'hFE;
        send_item(it);
        send_item(random_fields(CMD_REPORT));
        send_item(random_fields(CMD_REPORT));
        settle();
    endtask

    // zero and full-scale stale thresholds
    task automatic test_stale_thresholds();
        write_reg(REG_POINT_STALE, with_junk16(16'd0));
        write_reg(REG_IMU_STALE, with_junk16(16'd0));
        send_item(random_fields(CMD_REPORT));
        send_item(random_fields(CMD_TICK));
        send_item(random_fields(CMD_REPORT));
        settle();
        write_reg(REG_STARTUP_GRACE, with_junk16(16'd0));
        send_item(random_fields(CMD_REPORT));
        settle();
        write_reg(REG_POINT_STALE, with_junk16(16'hFFFF));
        write_reg(REG_IMU_STALE, with_junk16(16'hFFFF));
        send_item(random_fields(CMD_REPORT));
        settle();
    endtask

    // random traffic in phases, each under its own configuration
    task automatic test_random_traffic();
        item_t           it;
        logic [SeqW-1:0] seq_cursor;
        logic [AgeW-1:0] v;
        int              phase_sent;
        int              tick_w;
        int              burst;
        int              r;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_reg(REG_MATCH_ENABLE, ($urandom & ~32'h1) | (phase == 2 ? 32'h0 : 32'h1));
            case (phase % 4)
                0:       write_reg(REG_ACCEPT_HANDLE, 32'hFFFF_FFFF);
                1:       write_reg(REG_ACCEPT_HANDLE, 32'h0000_0000);
                default: write_reg(REG_ACCEPT_HANDLE, $urandom);
            endcase
            case (phase)
                0:       write_reg(REG_DEV_CODE, {24'($urandom), 8'hFF});
                1:       write_reg(REG_DEV_CODE, {24'($urandom), 8'h00});
                default: write_reg(REG_DEV_CODE, $urandom);
            endcase
            v = (phase == 3) ? 16'hFFFF : (phase == 4) ? 16'd0 : 16'($urandom_range(1, 40));
            write_reg(REG_POINT_STALE, with_junk16(v));
            v = (phase == 4) ? 16'hFFFF : (phase == 3) ? 16'd0 : 16'($urandom_range(1, 40));
            write_reg(REG_IMU_STALE, with_junk16(v));
            v = (phase == 5) ? 16'hFFFF : (phase == 6) ? 16'd0 : 16'($urandom_range(1, 600));
            write_reg(REG_STARTUP_GRACE, with_junk16(v));

            // one phase runs with no idling on either side
            idle_pct   = (phase == 7) ? 0 : IDLE_PCT;
            tick_w     = $urandom_range(10, 60);
            seq_cursor = 16'($urandom_range(65535));
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < tick_w)
                begin
                    burst = ($urandom_range(19) == 0) ? $urandom_range(5, 40) : 1;
                    repeat (burst)
                    begin
                        send_item(random_fields(CMD_TICK));
                        phase_sent++;
                    end
                end
                else
                begin
                    r = $urandom_range(99);
                    if (r < 12)
                    begin
                        it = random_fields(CMD_REPORT);
                    end
                    else
                    begin
                        seq_cursor = next_sequence(seq_cursor);
                        it = matched_packet((r < 45) ? CMD_IMU : CMD_POINT, seq_cursor,
                                            16'($urandom_range(65535)), {$urandom, $urandom});
                        case ($urandom_range(7))
                            0:       it.pkt_points = 16'd0;
                            1:       it.pkt_points = 16'hFFFF;
                            default: ;
                        endcase
                        // some packets from a foreign device
                        if ($urandom_range(99) < 12)
                        begin
                            if ($urandom_range(1)) it.handle   = $urandom;
                            else                   it.dev_code = 8'($urandom_range(255));
                        end
                    end
                    send_item(it);
                    phase_sent++;
                end
            end
            settle();
        end
        idle_pct = IDLE_PCT;
    endtask

    // main sequence
    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_POINT;
        in_ch.handle       = '0;
        in_ch.dev_code     = '0;
        in_ch.sequence_req = '0;
        in_ch.pkt_points   = '0;
        in_ch.timestamp    = '0;
        cfg_shadow.match_enable        = 1'b0;
        cfg_shadow.accepted_handle     = '0;
        cfg_shadow.expected_dev_code   = '0;
        cfg_shadow.point_stale_ticks   = POINT_STALE_DEFAULT;
        cfg_shadow.imu_stale_ticks     = IMU_STALE_DEFAULT;
        cfg_shadow.startup_grace_ticks = GRACE_DEFAULT;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_after_reset();
        test_startup_grace();
        test_sequence_gaps();
        test_stale_thresholds();
        test_random_traffic();
        settle();

        $display("run covered %0d input transactions, %0d reports and %0d register writes",
                 items_sent, reports_seen, reg_writes);
        $display("directed gap, threshold and grace cases plus %0d random traffic phases",
                 PHASE_COUNT);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d reports outstanding", pending_reports.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
